// File: rtl/kstt_pkg.sv
package kstt_pkg;

  // table depth, a power of two so the home slot is the low key bits
  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);

  localparam int KEY_W   = 32;
  localparam int TIME_W  = 64;
  localparam int FLAGS_W = 64;
  localparam int ADV_W   = 16;
  localparam int LEVEL_W = 3;
  localparam int REASON_W = 5;
  localparam int COUNT_W = 7;
  localparam int SLOT_W  = 6;

  localparam logic [1:0] CMD_EVAL   = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [LEVEL_W-1:0] LVL_COMPROMISED = 3'd4;
  localparam logic [LEVEL_W-1:0] LVL_MAX         = 3'd6;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [KEY_W-1:0]    pid;
    logic [KEY_W-1:0]    parent_pid;
    logic [TIME_W-1:0]   start_time;
    logic [FLAGS_W-1:0]  evidence_flags;
    logic [ADV_W-1:0]    advisory_level;
    logic [TIME_W-1:0]   exec_time;
    logic [TIME_W-1:0]   connect_time;
    logic [TIME_W-1:0]   clock_time;
    logic                rule_matched;
    logic [LEVEL_W-1:0]  rule_target_state;
    logic [REASON_W-1:0] rule_reason;
  } in_t;

  typedef struct packed {
    logic                found;
    logic                table_full;
    logic                level_moved;
    logic [LEVEL_W-1:0]  old_level;
    logic [LEVEL_W-1:0]  new_level;
    logic [REASON_W-1:0] change_reason;
    logic [COUNT_W-1:0]  evidence_count;
    logic [SLOT_W-1:0]   slot_index;
  } out_t;

endpackage

// File: rtl/keyed_state_tracker_table.sv
// keyed_state_tracker_table: per-process record table with linear probing
// usage
//   input: raise start with a command in item; the transfer happens at a
//   rising edge where start is high and busy is low. busy stays high until
//   the result has been produced
//   output: every command gives exactly one result, shown on result for one
//   cycle with done high; the receiver cannot hold it off
//   commands: evaluate finds or creates the record, updates its metadata and
//   applies the proposed level change; lookup reports a record; remove
//   reports it and then clears its valid bit
// timing
//   one probe per cycle through the record memory's registered read port,
//   starting at the home slot (low key bits) and walking forward with wrap
//   lookup / remove / table full: the result is registered as the last probe ends
//   evaluate with a record: after the probes, eight byte steps of the
//   shared bit-count adder, then the write-back state S_APPLY
//   worst case a full probe of all 64 slots; a new
//   item may be transferred in the same cycle its predecessor's result is shown
// reset: rst clears the sequencer, the strobe and all 64 valid bits at once;
//   record payload is only read behind a valid bit and needs no clearing
module keyed_state_tracker_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  kstt_pkg::in_t item,
  output logic          done,
  output kstt_pkg::out_t result
);

  // stored record, one memory word per slot
  typedef struct packed {
    logic [kstt_pkg::KEY_W-1:0]    key;
    logic [kstt_pkg::KEY_W-1:0]    parent;
    logic [kstt_pkg::TIME_W-1:0]   start_ns;
    logic [kstt_pkg::LEVEL_W-1:0]  level;
    logic [kstt_pkg::LEVEL_W-1:0]  prev_level;
    logic [kstt_pkg::REASON_W-1:0] reason;
    logic [kstt_pkg::TIME_W-1:0]   entered_time;
    logic [kstt_pkg::TIME_W-1:0]   evaluated_time;
    logic [kstt_pkg::COUNT_W-1:0]  evidence_count;
    logic [kstt_pkg::ADV_W-1:0]    advisory;
  } rec_t;

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PROBE = 2'd1;
  localparam logic [1:0] S_COUNT = 2'd2;
  localparam logic [1:0] S_APPLY = 2'd3;

  // bit count runs one byte of the evidence flags per step
  localparam int STEPS  = kstt_pkg::FLAGS_W / 8;
  localparam int STEP_W = $clog2(STEPS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS - 1);
  localparam logic [kstt_pkg::IDX_W-1:0] PROBE_LAST =
    kstt_pkg::IDX_W'(kstt_pkg::TABLE_ENTRIES - 1);

  logic [1:0]                        state;
  kstt_pkg::in_t                     req;
  logic [kstt_pkg::IDX_W-1:0]        idx;
  logic [kstt_pkg::IDX_W-1:0]        probe_cnt;
  logic [STEP_W-1:0]                 step;
  logic [kstt_pkg::COUNT_W-1:0]      acc;
  rec_t                              rec;
  logic [kstt_pkg::TABLE_ENTRIES-1:0] valid;

  // record memory, registered read
  rec_t                       mem [kstt_pkg::TABLE_ENTRIES];
  rec_t                       rd_data;
  logic [kstt_pkg::IDX_W-1:0] rd_addr;
  logic                       we;
  rec_t                       wr_rec;

  logic                         slot_valid;
  logic                         key_hit;
  logic                         probe_more;
  logic [7:0]                   flag_byte;
  logic [3:0]                   byte_ones;
  logic [kstt_pkg::TIME_W-1:0]  now;
  logic [kstt_pkg::LEVEL_W-1:0] target_sat;
  logic [kstt_pkg::LEVEL_W:0]   prev_inc;
  logic [kstt_pkg::LEVEL_W-1:0] target_lim;
  logic                         changed;
  rec_t                         new_rec;
  kstt_pkg::out_t               hit_report;
  kstt_pkg::out_t               full_report;

  function automatic logic [3:0] ones8(input logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'b000, b[i]};
    end
    return n;
  endfunction

  assign busy = (state != S_IDLE);

  // probe compare: the one key comparator, reused every probe cycle
  assign slot_valid = valid[idx];
  assign key_hit    = slot_valid && (rd_data.key == req.pid);
  assign probe_more = (state == S_PROBE) && slot_valid && !key_hit &&
                      (probe_cnt != PROBE_LAST);

  // read address runs one slot ahead so the next slot is read while this one is compared
  always_comb begin
    priority if (state == S_IDLE) begin
      rd_addr = item.pid[kstt_pkg::IDX_W-1:0];
    end else if (probe_more) begin
      rd_addr = idx + 1'b1;
    end else begin
      rd_addr = idx;
    end
  end

  // shared adder input for the bit count
  assign flag_byte = req.evidence_flags[{step, 3'b000} +: 8];
  assign byte_ones = ones8(flag_byte);

  // current time: first nonzero of exec, connect, clock
  always_comb begin
    priority if (req.exec_time != '0) begin
      now = req.exec_time;
    end else if (req.connect_time != '0) begin
      now = req.connect_time;
    end else begin
      now = req.clock_time;
    end
  end

  // proposed transition: saturate at LVL_MAX, clamp upward jumps to one level
  // except a jump straight to compromised
  always_comb begin
    target_sat = (req.rule_target_state > kstt_pkg::LVL_MAX) ?
                 kstt_pkg::LVL_MAX : req.rule_target_state;
    prev_inc   = {1'b0, rec.level} + 1'b1;
    target_lim = (({1'b0, target_sat} > prev_inc) &&
                  (target_sat != kstt_pkg::LVL_COMPROMISED)) ?
                 prev_inc[kstt_pkg::LEVEL_W-1:0] : target_sat;
    changed    = req.rule_matched && (target_lim != rec.level);
  end

  // merged record written back on evaluate
  always_comb begin
    wr_rec                = rec;
    wr_rec.parent         = (req.parent_pid != '0) ? req.parent_pid : rec.parent;
    wr_rec.start_ns       = (req.start_time != '0) ? req.start_time : rec.start_ns;
    wr_rec.evidence_count = acc;
    wr_rec.advisory       = req.advisory_level;
    wr_rec.evaluated_time = now;
    if (changed) begin
      wr_rec.prev_level   = rec.level;
      wr_rec.level        = target_lim;
      wr_rec.reason       = req.rule_reason;
      wr_rec.entered_time = now;
    end
  end

  // fresh record for a free slot
  always_comb begin
    new_rec        = '0;
    new_rec.key    = req.pid;
    new_rec.parent = req.parent_pid;
    new_rec.start_ns = req.start_time;
  end

  // lookup / remove report of a hit
  always_comb begin
    hit_report                = '0;
    hit_report.found          = 1'b1;
    hit_report.old_level      = rd_data.level;
    hit_report.new_level      = rd_data.level;
    hit_report.evidence_count = rd_data.evidence_count;
    hit_report.slot_index     = kstt_pkg::SLOT_W'(idx);
  end

  // evaluate that met neither the key nor a free slot
  always_comb begin
    full_report            = '0;
    full_report.table_full = 1'b1;
  end

  assign we = (state == S_APPLY);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[idx] <= wr_rec;
    end
    rd_data <= mem[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      valid <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            req       <= item;
            idx       <= item.pid[kstt_pkg::IDX_W-1:0];
            probe_cnt <= '0;
            state     <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (probe_more) begin
            done      <= 1'b0;
            idx       <= idx + 1'b1;
            probe_cnt <= probe_cnt + 1'b1;
          end else begin
            unique case (req.cmd)
              kstt_pkg::CMD_LOOKUP, kstt_pkg::CMD_REMOVE: begin
                result <= key_hit ? hit_report : '0;
                if (key_hit && (req.cmd == kstt_pkg::CMD_REMOVE)) begin
                  valid[idx] <= 1'b0;
                end
                done  <= 1'b1;
                state <= S_IDLE;
              end
              kstt_pkg::CMD_EVAL: begin
                priority if (key_hit) begin
                  rec   <= rd_data;
                  step  <= '0;
                  acc   <= '0;
                  done  <= 1'b0;
                  state <= S_COUNT;
                end else if (!slot_valid) begin
                  rec   <= new_rec;
                  step  <= '0;
                  acc   <= '0;
                  done  <= 1'b0;
                  state <= S_COUNT;
                end else begin
                  // every slot holds another key
                  result <= full_report;
                  done   <= 1'b1;
                  state  <= S_IDLE;
                end
              end
              default: begin
                // unknown command: no state touched, all-zero result
                result <= '0;
                done   <= 1'b1;
                state  <= S_IDLE;
              end
            endcase
          end
        end
        S_COUNT: begin
          done <= 1'b0;
          acc  <= acc + kstt_pkg::COUNT_W'(byte_ones);
          step <= step + 1'b1;
          if (step == STEP_LAST) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          valid[idx]            <= 1'b1;
          result.found          <= 1'b1;
          result.table_full     <= 1'b0;
          result.level_moved    <= changed;
          result.old_level      <= rec.level;
          result.new_level      <= changed ? target_lim : rec.level;
          result.change_reason  <= changed ? req.rule_reason : '0;
          result.evidence_count <= acc;
          result.slot_index     <= kstt_pkg::SLOT_W'(idx);
          done                  <= 1'b1;
          state                 <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/kstt_chk.sv
module kstt_chk (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input kstt_pkg::out_t result
);

  // a result strobe lasts one cycle
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // a transfer always starts work
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transfer taken but block not busy");

  // a result is shown only once the block is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // no record, no transition and no report
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.found) |->
      (!result.level_moved && (result.change_reason == '0) &&
       (result.slot_index == '0) && (result.evidence_count == '0)))
    else $error("miss result carries record fields");

  // a reported change really moves the level
  a_change_moves: assert property (@(posedge clk) disable iff (rst)
    (done && result.level_moved) |->
      (result.found && (result.new_level != result.old_level)))
    else $error("state change without a level move");

endmodule

bind keyed_state_tracker_table kstt_chk u_kstt_chk (.*);
